// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds at every rising edge outside of reset.
`define SRTF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/srtf_pkg.sv =====
`timescale 1ns / 1ps
package srtf_pkg;
	localparam int NUM_TASKS = 8;
	localparam int TIME_W    = 16;
	localparam int IDX_W     = 3;
	localparam int SLICE_W   = 8;
	localparam int ACT_W     = 4;
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
	localparam logic [SLICE_W-1:0] SLICE_MAX = {SLICE_W{1'b1}};

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic REG_TIME_SLICE   = 1'b0;
	localparam logic REG_ACTIVE_TASKS = 1'b1;

	typedef struct packed {
		logic              found;
		logic [TIME_W-1:0] rem;
		logic [IDX_W-1:0]  pick;
	} cand_t;

	typedef struct packed {
		logic load;
		logic charge;
		logic mark;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
		return (v == TIME_MAX) ? TIME_MAX : v + TIME_W'(1);
	endfunction
endpackage

// ===== rtl/shortest_remaining_time_scheduler_top.sv =====
// Loads and ticks needing no decision strobe the result in the cycle after acceptance.
// A tick that triggers a decision starts a scan: the candidate wave crosses the row
// of task cells one cell per cycle, and the result strobes when the scan ends.
// The receiver cannot stall; results are shown for exactly one cycle.
// Asynchronous active-low reset clears the task progress, time and selection, and sets
// the time slice register to 1 and the active-task register to 8.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module shortest_remaining_time_scheduler_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [srtf_pkg::IDX_W-1:0]   task_index,
	input  logic [srtf_pkg::TIME_W-1:0]  arrival_time,
	input  logic [srtf_pkg::TIME_W-1:0]  run_length,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [srtf_pkg::SLICE_W-1:0] cfg_data,
	output logic                         result_valid,
	output logic [srtf_pkg::TIME_W-1:0]  now,
	output logic                         running_valid,
	output logic [srtf_pkg::IDX_W-1:0]   running_task,
	output logic                         first_start,
	output logic                         done_event,
	output logic [srtf_pkg::IDX_W-1:0]   done_task
);
	srtf_pkg::state_t              state_q;
	logic [srtf_pkg::CNT_W-1:0]    count_q;
	logic [srtf_pkg::SLICE_W-1:0]  time_slice_q;
	logic [srtf_pkg::ACT_W-1:0]    active_q;
	logic [srtf_pkg::TIME_W-1:0]   time_q;
	logic [srtf_pkg::IDX_W-1:0]    current_q;
	logic                          running_q;
	logic [srtf_pkg::SLICE_W-1:0]  slice_q;
	logic                          fin_q;
	logic [srtf_pkg::IDX_W-1:0]    fin_task_q;

	logic                          res_valid_q;
	logic [srtf_pkg::TIME_W-1:0]   res_now_q;
	logic                          res_run_q;
	logic [srtf_pkg::IDX_W-1:0]    res_task_q;
	logic                          res_first_q;
	logic                          res_done_q;
	logic [srtf_pkg::IDX_W-1:0]    res_done_task_q;

	srtf_pkg::cell_ctrl_t          ctrl   [srtf_pkg::NUM_TASKS];
	srtf_pkg::cand_t               cands  [srtf_pkg::NUM_TASKS];
	logic [srtf_pkg::NUM_TASKS-1:0] en;
	logic [srtf_pkg::NUM_TASKS-1:0] fin_vec;
	logic [srtf_pkg::NUM_TASKS-1:0] started_vec;

	logic                          accept;
	logic                          is_load;
	logic                          is_tick;
	logic                          charge_now;
	logic                          fin_now;
	logic [srtf_pkg::SLICE_W-1:0]  slice_inc;
	logic                          decide;
	logic                          scan_end;
	srtf_pkg::cand_t               best;

	assign busy       = (state_q != srtf_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign is_load    = accept && (op == srtf_pkg::OP_LOAD);
	assign is_tick    = accept && (op == srtf_pkg::OP_TICK);
	assign charge_now = is_tick && running_q;
	assign fin_now    = running_q && fin_vec[current_q];
	assign slice_inc  = (slice_q == srtf_pkg::SLICE_MAX) ? slice_q
		: slice_q + srtf_pkg::SLICE_W'(1);
	assign decide     = !running_q || fin_now || (slice_inc >= time_slice_q);
	assign best       = cands[srtf_pkg::NUM_TASKS-1];
	assign scan_end   = (state_q == srtf_pkg::ST_SCAN)
		&& (count_q == srtf_pkg::CNT_W'(srtf_pkg::NUM_TASKS));

	for (genvar g = 0; g < srtf_pkg::NUM_TASKS; g++) begin : g_cell
		srtf_pkg::cand_t cin;

		assign en[g]       = (g < int'(active_q));
		assign ctrl[g].load   = is_load && (task_index == srtf_pkg::IDX_W'(g));
		assign ctrl[g].charge = charge_now && (current_q == srtf_pkg::IDX_W'(g));
		assign ctrl[g].mark   = scan_end && best.found && (best.pick == srtf_pkg::IDX_W'(g));

		if (g == 0) begin : g_head
			assign cin = '0;
		end else begin : g_link
			assign cin = cands[g-1];
		end

		srtf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cell_id     (srtf_pkg::IDX_W'(g)),
			.enable      (en[g]),
			.ctrl        (ctrl[g]),
			.arrival     (arrival_time),
			.length      (run_length),
			.time_now    (time_q),
			.cand_in     (cin),
			.cand_out    (cands[g]),
			.finish_next (fin_vec[g]),
			.started     (started_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= srtf_pkg::SLICE_W'(1);
			active_q     <= srtf_pkg::ACT_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				srtf_pkg::REG_TIME_SLICE:   time_slice_q <= cfg_data;
				srtf_pkg::REG_ACTIVE_TASKS: active_q     <= cfg_data[srtf_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= srtf_pkg::ST_IDLE;
			count_q         <= '0;
			time_q          <= '0;
			current_q       <= '0;
			running_q       <= 1'b0;
			slice_q         <= '0;
			fin_q           <= 1'b0;
			fin_task_q      <= '0;
			res_valid_q     <= 1'b0;
			res_now_q       <= '0;
			res_run_q       <= 1'b0;
			res_task_q      <= '0;
			res_first_q     <= 1'b0;
			res_done_q      <= 1'b0;
			res_done_task_q <= '0;
		end else begin
			case (state_q)
				srtf_pkg::ST_IDLE: begin
					res_valid_q <= is_load || (is_tick && !decide);
					if (is_load) begin
						res_now_q       <= time_q;
						res_run_q       <= running_q;
						res_task_q      <= running_q ? current_q : '0;
						res_first_q     <= 1'b0;
						res_done_q      <= 1'b0;
						res_done_task_q <= '0;
					end else if (is_tick) begin
						time_q <= srtf_pkg::sat_inc(time_q);
						if (decide) begin
							slice_q    <= '0;
							fin_q      <= fin_now;
							fin_task_q <= fin_now ? current_q : '0;
							count_q    <= '0;
							state_q    <= srtf_pkg::ST_SCAN;
						end else begin
							slice_q         <= slice_inc;
							res_now_q       <= srtf_pkg::sat_inc(time_q);
							res_run_q       <= running_q;
							res_task_q      <= current_q;
							res_first_q     <= 1'b0;
							res_done_q      <= 1'b0;
							res_done_task_q <= '0;
						end
					end
				end
				srtf_pkg::ST_SCAN: begin
					count_q     <= count_q + srtf_pkg::CNT_W'(1);
					res_valid_q <= scan_end;
					if (scan_end) begin
						state_q         <= srtf_pkg::ST_IDLE;
						running_q       <= best.found;
						current_q       <= best.found ? best.pick : '0;
						res_now_q       <= time_q;
						res_run_q       <= best.found;
						res_task_q      <= best.found ? best.pick : '0;
						res_first_q     <= best.found && !started_vec[best.pick];
						res_done_q      <= fin_q;
						res_done_task_q <= fin_task_q;
					end
				end
				default: begin
					res_valid_q <= 1'b0;
					state_q     <= srtf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid  = res_valid_q;
	assign now           = res_now_q;
	assign running_valid = res_run_q;
	assign running_task  = res_task_q;
	assign first_start   = res_first_q;
	assign done_event    = res_done_q;
	assign done_task     = res_done_task_q;

	`SRTF_ASSERT(a_result_when_idle, !result_valid || !busy, "result shown while an item is in work")
	`SRTF_ASSERT(a_scan_bounded,
		(state_q != srtf_pkg::ST_SCAN) || (count_q <= srtf_pkg::CNT_W'(srtf_pkg::NUM_TASKS)),
		"candidate scan ran past the last cell")
	`SRTF_ASSERT(a_idle_task_zero, !result_valid || running_valid || (running_task == '0),
		"task index shown with no task running")
	`SRTF_ASSERT_NEXT(a_accept_progress, start && !busy, busy || result_valid,
		"accepted item neither produced a result nor started a scan")
endmodule

// ===== rtl/srtf_cell.sv =====
`timescale 1ns / 1ps
module srtf_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [srtf_pkg::IDX_W-1:0]  cell_id,
	input  logic                        enable,
	input  srtf_pkg::cell_ctrl_t        ctrl,
	input  logic [srtf_pkg::TIME_W-1:0] arrival,
	input  logic [srtf_pkg::TIME_W-1:0] length,
	input  logic [srtf_pkg::TIME_W-1:0] time_now,
	input  srtf_pkg::cand_t             cand_in,
	output srtf_pkg::cand_t             cand_out,
	output logic                        finish_next,
	output logic                        started
);
	logic [srtf_pkg::TIME_W-1:0] arrival_q;
	logic [srtf_pkg::TIME_W-1:0] length_q;
	logic [srtf_pkg::TIME_W-1:0] consumed_q;
	logic                        done_q;
	logic                        started_q;
	srtf_pkg::cand_t             cand_q;
	logic [srtf_pkg::TIME_W-1:0] consumed_inc;
	logic [srtf_pkg::TIME_W-1:0] rem;
	logic                        qual;
	logic                        take;

	assign consumed_inc = srtf_pkg::sat_inc(consumed_q);
	assign finish_next  = (consumed_inc >= length_q);
	assign rem          = (consumed_q >= length_q) ? '0 : length_q - consumed_q;
	assign qual         = enable && !done_q && (arrival_q <= time_now);
	assign take         = qual && (!cand_in.found || (rem < cand_in.rem));
	assign cand_out     = cand_q;
	assign started      = started_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			arrival_q <= arrival;
			length_q  <= length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumed_q <= '0;
			done_q     <= 1'b0;
			started_q  <= 1'b0;
			cand_q     <= '0;
		end else begin
			if (ctrl.load) begin
				consumed_q <= '0;
				done_q     <= 1'b0;
				started_q  <= 1'b0;
			end else begin
				if (ctrl.charge) begin
					consumed_q <= consumed_inc;
					done_q     <= finish_next;
				end
				if (ctrl.mark) begin
					started_q <= 1'b1;
				end
			end
			if (take) begin
				cand_q.found <= 1'b1;
				cand_q.rem   <= rem;
				cand_q.pick  <= cell_id;
			end else begin
				cand_q <= cand_in;
			end
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import srtf_pkg::*;

	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] length;
	} sched_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic              running_valid;
		logic [IDX_W-1:0]  running_task;
		logic              first_start;
		logic              done_event;
		logic [IDX_W-1:0]  done_task;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_TIME_SLICE;
	logic [SLICE_W-1:0] cfg_data = '0;
	sched_item_t drv_item = '0;

	wire                busy;
	wire                result_valid;
	wire [TIME_W-1:0]   now;
	wire                running_valid;
	wire [IDX_W-1:0]    running_task;
	wire                first_start;
	wire                done_event;
	wire [IDX_W-1:0]    done_task;

	shortest_remaining_time_scheduler_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (drv_item.op),
		.task_index   (drv_item.idx),
		.arrival_time (drv_item.arrival),
		.run_length   (drv_item.length),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.now          (now),
		.running_valid(running_valid),
		.running_task (running_task),
		.first_start  (first_start),
		.done_event   (done_event),
		.done_task    (done_task)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Scheduler state as the testbench expects it.
	logic [TIME_W-1:0]  tk_arrival [NUM_TASKS];
	logic [TIME_W-1:0]  tk_length  [NUM_TASKS];
	logic [TIME_W-1:0]  tk_used    [NUM_TASKS];
	logic               tk_done    [NUM_TASKS];
	logic               tk_started [NUM_TASKS];
	logic [TIME_W-1:0]  clock_now = '0;
	logic [IDX_W-1:0]   cur_task = '0;
	logic               sel_valid = 1'b0;
	logic [SLICE_W-1:0] slice_used = '0;
	logic [SLICE_W-1:0] slice_cfg = 8'd1;
	logic [ACT_W-1:0]   active_cfg = 4'd8;

	sched_item_t   pending_items[$];
	sched_result_t expected_results[$];
	int  fail_count = 0;
	int  queued = 0;
	int  plan_time = 0;
	bit  item_taken = 1'b0;
	bit  gaps_on = 1'b1;
	int  burst_left = 0;
	int  gap_left = 0;

	initial begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			tk_arrival[i] = '0;
			tk_length[i] = '0;
			tk_used[i] = '0;
			tk_done[i] = 1'b0;
			tk_started[i] = 1'b0;
		end
	end

	function automatic sched_result_t schedule_step(input sched_item_t it);
		sched_result_t r;
		logic decide;
		logic found;
		logic [TIME_W-1:0] best;
		logic [TIME_W-1:0] rem;
		logic [IDX_W-1:0] pick;
		int lim;
		r = '0;
		pick = '0;
		if (it.op == OP_LOAD) begin
			tk_arrival[it.idx] = it.arrival;
			tk_length[it.idx] = it.length;
			tk_used[it.idx] = '0;
			tk_done[it.idx] = 1'b0;
			tk_started[it.idx] = 1'b0;
		end else begin
			decide = !sel_valid;
			if (clock_now != TIME_MAX)
				clock_now = clock_now + 1'b1;
			if (sel_valid) begin
				if (tk_used[cur_task] != TIME_MAX)
					tk_used[cur_task] = tk_used[cur_task] + 1'b1;
				if (slice_used != SLICE_MAX)
					slice_used = slice_used + 1'b1;
				if (tk_used[cur_task] >= tk_length[cur_task]) begin
					tk_done[cur_task] = 1'b1;
					r.done_event = 1'b1;
					r.done_task = cur_task;
					decide = 1'b1;
				end
				if (slice_used >= slice_cfg)
					decide = 1'b1;
			end
			if (decide) begin
				slice_used = '0;
				found = 1'b0;
				best = '0;
				lim = (active_cfg > NUM_TASKS) ? NUM_TASKS : int'(active_cfg);
				for (int i = 0; i < lim; i++) begin
					if (!tk_done[i] && tk_arrival[i] <= clock_now) begin
						rem = (tk_used[i] >= tk_length[i]) ? '0 : tk_length[i] - tk_used[i];
						if (!found || rem < best) begin
							found = 1'b1;
							best = rem;
							pick = IDX_W'(i);
						end
					end
				end
				if (found) begin
					sel_valid = 1'b1;
					cur_task = pick;
					r.first_start = !tk_started[pick];
					tk_started[pick] = 1'b1;
				end else begin
					sel_valid = 1'b0;
					cur_task = '0;
				end
			end
		end
		r.now = clock_now;
		r.running_valid = sel_valid;
		r.running_task = sel_valid ? cur_task : '0;
		return r;
	endfunction

	// Item acceptance and prediction.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_results.push_back(schedule_step(drv_item));
			item_taken = 1'b1;
		end
	end

	// Sender: bursts of items separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			item_taken = 1'b0;
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_items.size() > 0) begin
				drv_item <= pending_items.pop_front();
				start <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if (!gaps_on || $urandom_range(0, 2) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("now", want.now, now);
				check_field("running_valid", want.running_valid, running_valid);
				check_field("running_task", want.running_task, running_task);
				check_field("first_start", want.first_start, first_start);
				check_field("done_event", want.done_event, done_event);
				check_field("done_task", want.done_task, done_task);
			end
		end
	end

	task automatic push_load(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] arr,
			input logic [TIME_W-1:0] len);
		sched_item_t it;
		it.op = OP_LOAD;
		it.idx = idx;
		it.arrival = arr;
		it.length = len;
		pending_items.push_back(it);
		queued++;
	endtask

	task automatic push_tick();
		sched_item_t it;
		it.op = OP_TICK;
		it.idx = IDX_W'($urandom());
		it.arrival = TIME_W'($urandom());
		it.length = TIME_W'($urandom());
		pending_items.push_back(it);
		queued++;
		if (plan_time < TIME_MAX)
			plan_time++;
	endtask

	function automatic logic [TIME_W-1:0] near_arrival();
		int a;
		a = plan_time + int'($urandom_range(0, 12));
		if ($urandom_range(0, 4) == 0)
			a = plan_time - int'($urandom_range(0, 3));
		if (a < 0)
			a = 0;
		if (a > TIME_MAX)
			a = TIME_MAX;
		return TIME_W'(a);
	endfunction

	function automatic logic [TIME_W-1:0] short_length();
		if ($urandom_range(0, 5) == 0)
			return TIME_W'($urandom_range(0, 1));
		return TIME_W'($urandom_range(1, 24));
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [SLICE_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TIME_SLICE)
			slice_cfg = data;
		else
			active_cfg = data[ACT_W-1:0];
	endtask

	task automatic gen_random(input int count);
		int target;
		int kind;
		target = queued + count;
		while (queued < target) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				repeat ($urandom_range(1, 3))
					push_load(IDX_W'($urandom_range(0, NUM_TASKS - 1)), near_arrival(),
						short_length());
				repeat ($urandom_range(3, 15))
					push_tick();
			end else if (kind < 9) begin
				repeat ($urandom_range(1, 30))
					push_tick();
			end else if ($urandom_range(0, 1) == 0) begin
				push_load(IDX_W'($urandom()), TIME_W'($urandom()), TIME_W'($urandom()));
			end else begin
				push_tick();
			end
		end
	endtask

	initial begin
		logic [SLICE_W-1:0] phase_slice [7];
		logic [SLICE_W-1:0] phase_active [7];
		phase_slice  = '{8'd255, 8'd0, 8'd3, 8'd1, 8'd7, 8'd2, 8'd128};
		phase_active = '{8'h0F, 8'h03, 8'h00, 8'h01, 8'hF5, 8'h09, 8'h08};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every entry is loaded before the first tick, so no search reads an empty entry.
		push_load(3'd0, 16'd0, 16'd3);
		push_load(3'd1, 16'd0, 16'd1);
		push_load(3'd2, 16'd2, 16'd0);
		push_load(3'd3, 16'hFFFF, 16'hFFFF);
		push_load(3'd4, 16'd1, 16'd2);
		push_load(3'd5, 16'd0, 16'd1);
		push_load(3'd6, 16'd5, 16'h8000);
		push_load(3'd7, 16'h7FFF, 16'd4);
		repeat (4) push_tick();
		push_load(3'd0, 16'd0, 16'd2);
		repeat (6) push_tick();
		push_load(3'd6, 16'd0, 16'h7FFF);
		repeat (4) push_tick();
		wait_drained();

		for (int p = 0; p < 7; p++) begin
			write_reg(REG_TIME_SLICE, phase_slice[p]);
			write_reg(REG_ACTIVE_TASKS, phase_active[p]);
			gen_random(80);
			wait_drained();
		end

		// Long slice with every entry in use and some arrivals far in the future.
		gaps_on = 1'b0;
		write_reg(REG_TIME_SLICE, 8'd255);
		write_reg(REG_ACTIVE_TASKS, 8'd8);
		for (int i = 0; i < 6; i++)
			push_load(IDX_W'(i), 16'd0, 16'hFFFF);
		push_load(3'd6, 16'hFFF0, 16'd16);
		push_load(3'd7, 16'hFFFF, 16'd2);
		repeat (20) push_tick();
		push_load(3'd5, 16'd0, 16'd0);
		repeat (8) push_tick();
		wait_drained();

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#50000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
